// ----- rtl/rde_pkg.sv -----
// shared types, constants and helpers of the radix digit emitter
`default_nettype none
package rde_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int RADIX_BITS   = 5;
    localparam int DIGIT_BITS   = 4;
    localparam int CNT_BITS     = 6;
    localparam int SYM_BITS     = 8;
    localparam int SYMTAB_BITS  = 64;
    localparam int CFG_IDX_BITS = 2;
    // quotient bits resolved per cycle by the shared divide step
    localparam int BITS_PER_STEP = 8;
    localparam int STEPS_PER_DIGIT = VALUE_BITS / BITS_PER_STEP;
    localparam int STEP_BITS = $clog2(STEPS_PER_DIGIT);

    localparam logic [SYM_BITS-1:0]    MINUS_SYMBOL = 8'h2D;
    localparam logic [RADIX_BITS-1:0]  RADIX_MIN    = 5'd2;
    localparam logic [RADIX_BITS-1:0]  RADIX_MAX    = 5'd16;
    localparam logic [RADIX_BITS-1:0]  RADIX_RESET  = 5'd10;
    localparam logic [SYMTAB_BITS-1:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [SYMTAB_BITS-1:0] SYMBOLS_HIGH_RESET = 64'h6665646362613938;

    localparam logic [CFG_IDX_BITS-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
        logic [RADIX_BITS-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [SYM_BITS-1:0] symbol_of(
        input logic [DIGIT_BITS-1:0]  d,
        input logic [SYMTAB_BITS-1:0] lo,
        input logic [SYMTAB_BITS-1:0] hi
    );
        logic [SYMTAB_BITS-1:0] tab;
        tab = d[DIGIT_BITS-1] ? hi : lo;
        return tab[d[DIGIT_BITS-2:0]*SYM_BITS +: SYM_BITS];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/radix_digit_emitter.sv -----
// signed integer to radix text converter with a shared long-division step unit
// operation: after a value is accepted, each digit is produced by the shared
// 8-bit-per-cycle divide step working through the whole value; the sign or first word
// is loaded once the output is free after the last digit; not ready for a new value
// until the last word is loaded
// reset: synchronous active low; control cleared, radix 10, symbols "0123456789abcdef"
// digit store is not reset, every entry is written before it is read
`default_nettype none
module radix_digit_emitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream: tdata[31:0] value
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [rde_pkg::VALUE_BITS-1:0] i_s_axis_tdata,
    // output stream: tdata[7:0] symbol, tlast marks the final symbol
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [rde_pkg::SYM_BITS-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [rde_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [rde_pkg::SYMTAB_BITS-1:0]  i_cfg_data
);

    rde_pkg::t_state r_state, n_state;

    logic [rde_pkg::RADIX_BITS-1:0]  r_radix;
    logic [rde_pkg::SYMTAB_BITS-1:0] r_sym_lo;
    logic [rde_pkg::SYMTAB_BITS-1:0] r_sym_hi;

    logic [rde_pkg::VALUE_BITS-1:0] r_mag;
    logic [rde_pkg::DIGIT_BITS-1:0] r_rem;
    logic [rde_pkg::RADIX_BITS-1:0] r_base;
    logic                           r_neg;
    logic [rde_pkg::STEP_BITS-1:0]  r_step;
    logic [rde_pkg::CNT_BITS-1:0]   r_cnt;

    logic [rde_pkg::DIGIT_BITS-1:0] r_digits [rde_pkg::VALUE_BITS];

    logic                         r_m_valid;
    logic [rde_pkg::SYM_BITS-1:0] r_m_sym;
    logic                         r_m_last;

    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_load;
    logic                           w_last;
    logic [rde_pkg::VALUE_BITS-1:0] w_mag_nx;
    logic [rde_pkg::DIGIT_BITS-1:0] w_rem_nx;
    logic                           w_digit_done;
    logic [rde_pkg::CNT_BITS-2:0]   w_rd_idx;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_digit_done = (r_step == rde_pkg::STEP_BITS'(rde_pkg::STEPS_PER_DIGIT - 1));
    assign w_rd_idx = r_cnt[rde_pkg::CNT_BITS-2:0] - 1'b1;

    // shared divide step: top byte of the dividend through 8 compare/subtract stages
    always_comb begin
        logic [rde_pkg::RADIX_BITS-1:0]    rem5;
        logic [rde_pkg::DIGIT_BITS-1:0]    rem;
        logic [rde_pkg::BITS_PER_STEP-1:0] quo;
        logic [rde_pkg::BITS_PER_STEP-1:0] top;
        rem = r_rem;
        quo = '0;
        top = r_mag[rde_pkg::VALUE_BITS-1 -: rde_pkg::BITS_PER_STEP];
        for (int i = rde_pkg::BITS_PER_STEP - 1; i >= 0; i--) begin
            rem5 = {rem, top[i]};
            if (rem5 >= r_base) begin
                rem5 = rem5 - r_base;
                quo[i] = 1'b1;
            end
            rem = rem5[rde_pkg::DIGIT_BITS-1:0];
        end
        w_rem_nx = rem;
        w_mag_nx = {r_mag[rde_pkg::VALUE_BITS-rde_pkg::BITS_PER_STEP-1:0], quo};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rde_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = rde_pkg::ST_DIV;
                end
            end
            rde_pkg::ST_DIV: begin
                if (w_digit_done && (w_mag_nx == '0)) begin
                    n_state = r_neg ? rde_pkg::ST_SIGN : rde_pkg::ST_EMIT;
                end
            end
            rde_pkg::ST_SIGN: begin
                if (w_out_free) begin
                    n_state = rde_pkg::ST_EMIT;
                end
            end
            rde_pkg::ST_EMIT: begin
                if (w_out_free && (r_cnt == rde_pkg::CNT_BITS'(1))) begin
                    n_state = rde_pkg::ST_IDLE;
                end
            end
            default: n_state = rde_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_load = 1'b0;
        w_last = 1'b0;
        case (r_state)
            rde_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            rde_pkg::ST_DIV: begin
                w_load = 1'b0;
            end
            rde_pkg::ST_SIGN: begin
                w_load = w_out_free;
            end
            rde_pkg::ST_EMIT: begin
                w_load = w_out_free;
                w_last = (r_cnt == rde_pkg::CNT_BITS'(1));
            end
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_sym;
    assign o_m_axis_tlast  = r_m_last;

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rde_pkg::ST_IDLE;
            r_radix   <= rde_pkg::RADIX_RESET;
            r_sym_lo  <= rde_pkg::SYMBOLS_LOW_RESET;
            r_sym_hi  <= rde_pkg::SYMBOLS_HIGH_RESET;
            r_m_valid <= 1'b0;
            r_cnt     <= '0;
            r_step    <= '0;
            r_rem     <= '0;
            r_base    <= rde_pkg::RADIX_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rde_pkg::REG_RADIX:
                        r_radix <= rde_pkg::clamp_radix(i_cfg_data[rde_pkg::RADIX_BITS-1:0]);
                    rde_pkg::REG_SYMBOLS_LOW:  r_sym_lo <= i_cfg_data;
                    rde_pkg::REG_SYMBOLS_HIGH: r_sym_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                rde_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cnt  <= '0;
                        r_step <= '0;
                        r_rem  <= '0;
                        r_base <= r_radix;
                    end
                end
                rde_pkg::ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (w_digit_done) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_rem <= '0;
                    end else begin
                        r_rem <= w_rem_nx;
                    end
                end
                rde_pkg::ST_EMIT: begin
                    if (w_out_free) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_neg <= i_s_axis_tdata[rde_pkg::VALUE_BITS-1];
            // the most negative value negates to its own unsigned magnitude
            r_mag <= i_s_axis_tdata[rde_pkg::VALUE_BITS-1] ?
                     (~i_s_axis_tdata + 1'b1) : i_s_axis_tdata;
        end else if (r_state == rde_pkg::ST_DIV) begin
            r_mag <= w_mag_nx;
        end
        if ((r_state == rde_pkg::ST_DIV) && w_digit_done) begin
            r_digits[r_cnt[rde_pkg::CNT_BITS-2:0]] <= w_rem_nx;
        end
        if (w_load) begin
            // digits leave most significant first, the sign word goes ahead of them
            r_m_sym  <= (r_state == rde_pkg::ST_EMIT) ?
                        rde_pkg::symbol_of(r_digits[w_rd_idx], r_sym_lo, r_sym_hi) :
                        rde_pkg::MINUS_SYMBOL;
            r_m_last <= w_last;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rde_pkg::CNT_BITS'(rde_pkg::VALUE_BITS))
        else $error("digit count beyond value width");

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rde_pkg::ST_EMIT) |-> (r_cnt != '0))
        else $error("emitting with no digit stored");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == rde_pkg::ST_DIV) && (r_cnt == '0) && (r_step == '0))
        else $error("accepted value did not start division");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rde_pkg::ST_DIV) |-> ({1'b0, r_rem} < r_base))
        else $error("partial remainder not below radix");

    a_last_ends_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == rde_pkg::ST_IDLE))
        else $error("final word loaded but sequencer not idle");

endmodule
`default_nettype wire
